### rtl/core/urlx_pkg.sv
// types, character codes and helper functions shared by the url prefix extractor
package urlx_pkg;

   localparam logic [7:0] CH_H     = 8'h68;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_P     = 8'h70;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [2:0] PRE_NONE  = 3'd0;
   localparam logic [2:0] PRE_HTTP  = 3'd5;
   localparam logic [2:0] PRE_HTTPS = 3'd6;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_H    = 7'b0000010,
      ST_T1   = 7'b0000100,
      ST_T2   = 7'b0001000,
      ST_P    = 7'b0010000,
      ST_S    = 7'b0100000,
      ST_URL  = 7'b1000000
   } state_type;

   // results caused by one input character, in order: prefix, character, marker
   typedef struct packed {
      logic [2:0] pre_len;
      logic       has_char;
      logic [7:0] ch;
      logic       has_mark;
      logic       mark_cut;
   } burst_type;

   function automatic logic is_legal(input logic [7:0] c);
      logic [7:0] f;
      logic       ok;
      f = c;
      if (c >= 8'h41 && c <= 8'h5a) begin
         f = c + 8'h20;
      end
      ok = (f >= 8'h61 && f <= 8'h7a) || (f >= 8'h30 && f <= 8'h39);
      case (f)
         8'h2e, 8'h2f, 8'h5c, 8'h7e, 8'h23, 8'h25, 8'h26, 8'h28,
         8'h29, 8'h5f, 8'h2d, 8'h2b, 8'h3d, 8'h3b, 8'h3f: begin
            ok = 1'b1;
         end
         default: begin
         end
      endcase
      return ok;
   endfunction

   function automatic logic [7:0] prefix_char(input logic [2:0] idx, input logic with_s);
      logic [7:0] r;
      case (idx)
         3'd0: begin
            r = CH_H;
         end
         3'd1, 3'd2: begin
            r = CH_T;
         end
         3'd3: begin
            r = CH_P;
         end
         3'd4: begin
            r = with_s ? CH_S : CH_COLON;
         end
         default: begin
            r = CH_COLON;
         end
      endcase
      return r;
   endfunction

   function automatic logic [2:0] burst_count(input burst_type b);
      return 3'(b.pre_len + 3'(b.has_char) + 3'(b.has_mark));
   endfunction

endpackage

### rtl/core/urlx_matcher.sv
// prefix match state and per-character result burst decode
module urlx_matcher
   import urlx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] in_char,
   input  logic       line_last,
   input  logic       accept,
   output burst_type  burst
);

   state_type state_ff;
   state_type state_in;
   state_type nxt;
   logic      ended;

   always_comb begin
      burst    = '0;
      ended    = 1'b0;
      nxt      = ST_IDLE;
      case (state_ff)
         ST_H: begin
            nxt = (in_char == CH_T) ? ST_T1 : ST_IDLE;
         end
         ST_T1: begin
            nxt = (in_char == CH_T) ? ST_T2 : ST_IDLE;
         end
         ST_T2: begin
            nxt = (in_char == CH_P) ? ST_P : ST_IDLE;
         end
         ST_P, ST_S: begin
            if (in_char == CH_COLON) begin
               burst.pre_len = (state_ff == ST_S) ? PRE_HTTPS : PRE_HTTP;
               nxt           = ST_URL;
            end else if (state_ff == ST_P && in_char == CH_S) begin
               nxt = ST_S;
            end else begin
               nxt = ST_IDLE;
            end
         end
         ST_URL: begin
            if (is_legal(in_char)) begin
               burst.has_char = 1'b1;
               burst.ch       = in_char;
               nxt            = ST_URL;
            end else begin
               burst.has_mark = 1'b1;
               ended          = 1'b1;
               nxt            = (in_char == CH_H) ? ST_H : ST_IDLE;
            end
         end
         default: begin
            nxt = (in_char == CH_H) ? ST_H : ST_IDLE;
         end
      endcase
      state_in = nxt;
      if (line_last) begin
         if (nxt == ST_URL && !ended) begin
            burst.has_mark = 1'b1;
            burst.mark_cut = 1'b1;
         end
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/url_prefix_extractor_unit.sv
// top level: url prefix extractor with burst emitter and registered result stage
// Takes one character per transfer and gives the url characters and end markers
// it causes. A character that yields zero or one result is taken every cycle
// while the result side keeps up. The colon completing an "http:" or "https:"
// prefix yields up to seven results, sent one per cycle from a burst register
// while the result side keeps up; the input then holds off until the last of
// them leaves. Results leave through a result register loaded from the burst
// register.
module url_prefix_extractor_unit
   import urlx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // in_char
   input  logic       req_tlast,   // line_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_char
   output logic [2:0] rsp_tuser,   // char_valid, url_done, cut_by_line_end
   output logic       rsp_tlast    // run_last
);

   burst_type  new_burst;
   burst_type  burst_ff;
   logic       busy_ff;
   logic [2:0] idx_ff;
   logic       accept;
   logic       out_free;
   logic       emit;
   logic       item_last;
   logic [2:0] total;

   logic       rsp_valid_ff;
   logic [7:0] rsp_char_ff;
   logic [2:0] rsp_user_ff;
   logic       rsp_last_ff;
   logic [7:0] item_char;
   logic [2:0] item_user;

   urlx_matcher u_matcher (
      .clock     (clock),
      .reset     (reset),
      .in_char   (req_tdata),
      .line_last (req_tlast),
      .accept    (accept),
      .burst     (new_burst)
   );

   assign total      = burst_count(burst_ff);
   assign item_last  = (idx_ff == 3'(total - 3'd1));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit       = busy_ff && out_free;
   assign req_tready = !busy_ff || (emit && item_last);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (idx_ff < burst_ff.pre_len) begin
         item_char = prefix_char(idx_ff, burst_ff.pre_len == PRE_HTTPS);
         item_user = 3'b001;
      end else if (burst_ff.has_char && idx_ff == burst_ff.pre_len) begin
         item_char = burst_ff.ch;
         item_user = 3'b001;
      end else begin
         item_char = CH_NUL;
         item_user = {burst_ff.mark_cut, 1'b1, 1'b0};
      end
   end

   // burst register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 3'd0;
      end else if (accept) begin
         busy_ff <= (burst_count(new_burst) != 3'd0);
         idx_ff  <= 3'd0;
      end else if (emit) begin
         if (item_last) begin
            busy_ff <= 1'b0;
         end
         idx_ff <= 3'(idx_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         burst_ff <= new_burst;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_char_ff <= item_char;
         rsp_user_ff <= item_user;
         rsp_last_ff <= item_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
